### hdl/typed_frame_deframer_defines.svh
// ----------------------------------------------------------------------------
// Typed frame deframer assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef TYPED_FRAME_DEFRAMER_DEFINES_SVH
`define TYPED_FRAME_DEFRAMER_DEFINES_SVH

// Check a property on every rising edge outside reset
`define TFD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check a property on every rising edge, reset included
`define TFD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/tfd_pkg.sv
// ----------------------------------------------------------------------------
// Typed frame deframer package
// Sizes, type codes, register indexes and the structs shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tfd_pkg;

  // Frame store geometry
  localparam int MAX_FRAME_LEN = 64;
  localparam int TYPE_SLOTS    = 16;
  localparam int ADDR_W        = $clog2(MAX_FRAME_LEN);
  localparam int CNT_W         = $clog2(MAX_FRAME_LEN + 1);

  // Field widths
  localparam int BYTE_W     = 8;
  localparam int INDEX_W    = 6;
  localparam int TYPE_W     = 4;
  localparam int LEN_W      = 7;
  localparam int TCOUNT_W   = 5;
  localparam int OVH_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Message type codes with a variable length
  localparam logic [TYPE_W-1:0] BUS_TYPE     = 4'd2;
  localparam logic [TYPE_W-1:0] CHUNK_TYPE_A = 4'd6;
  localparam logic [TYPE_W-1:0] CHUNK_TYPE_B = 4'd9;

  localparam logic [BYTE_W-1:0] BUS_COUNT_MAX = 8'd8;
  localparam logic [BYTE_W-1:0] MIN_TABLE_LEN = 8'd2;
  localparam logic [CNT_W-1:0]  COUNT_POS     = CNT_W'(3);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_BYTE  = 3'd0,
    REG_TYPE_COUNT  = 3'd1,
    REG_LENGTHS_LO  = 3'd2,
    REG_LENGTHS_HI  = 3'd3,
    REG_BUS_OVH     = 3'd4,
    REG_CHUNK_OVH   = 3'd5,
    REG_CHUNK_MAX   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [BYTE_W-1:0]     start_byte;
    logic [TCOUNT_W-1:0]   type_count;
    logic [CFG_DATA_W-1:0] lengths_lo;
    logic [CFG_DATA_W-1:0] lengths_hi;
    logic [OVH_W-1:0]      bus_ovh;
    logic [OVH_W-1:0]      chunk_ovh;
    logic [OVH_W-1:0]      chunk_max;
  } cfg_t;

  // Frame store write port
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } mem_wr_t;

  // Frame store read port
  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

  // Completed frame handed from receiver to emitter
  typedef struct packed {
    logic              start;
    logic [TYPE_W-1:0] ftype;
    logic [LEN_W-1:0]  flen;
  } emit_req_t;

endpackage

`default_nettype wire

### hdl/tfd_byte_if.sv
// ----------------------------------------------------------------------------
// Byte input channel
// Valid/ready channel carrying one received byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfd_byte_if import tfd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

### hdl/tfd_frame_if.sv
// ----------------------------------------------------------------------------
// Frame output channel
// Valid/ready channel carrying one byte of a completed frame per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfd_frame_if import tfd_pkg::*;;
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  frame_byte;
  logic [INDEX_W-1:0] byte_index;
  logic [TYPE_W-1:0]  frame_type;
  logic [LEN_W-1:0]   frame_length;
  logic               last_byte;

  modport source (output valid, output frame_byte, output byte_index, output frame_type,
                  output frame_length, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input byte_index, input frame_type,
                  input frame_length, input last_byte, output ready);
endinterface

`default_nettype wire

### hdl/tfd_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfd_cfg_if import tfd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/tfd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data held between reads.
// ----------------------------------------------------------------------------
`default_nettype none

module tfd_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/tfd_hunt.sv
// ----------------------------------------------------------------------------
// Frame receiver
// Hunts for start and type bytes, tracks the frame length and writes each
// frame byte into the frame store. Flags a completed frame to the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module tfd_hunt import tfd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [BYTE_W-1:0] data_byte,
  input  cfg_t              cfg,
  output mem_wr_t           wr,
  output emit_req_t         req
);

  typedef enum logic [1:0] {
    S_HUNT,
    S_TYPE,
    S_BODY
  } state_t;

  state_t              state, state_next;
  logic [TYPE_W-1:0]   cur_type, cur_type_next;
  logic [CNT_W-1:0]    rcount, rcount_next;
  logic [CNT_W-1:0]    exp_len, exp_len_next;
  logic [CNT_W-1:0]    rcount_inc;
  logic [TCOUNT_W-1:0] limit;
  logic [CFG_DATA_W-1:0] tbl_word;
  logic [BYTE_W-1:0]   tbl_raw;
  logic [BYTE_W-1:0]   tlen;
  logic                bad_count;
  logic [BYTE_W:0]     plen;

  function automatic logic is_variable(input logic [TYPE_W-1:0] t);
    return (t == BUS_TYPE) || (t == CHUNK_TYPE_A) || (t == CHUNK_TYPE_B);
  endfunction

  // Type limit, table length and patched length
  always_comb begin
    limit    = (cfg.type_count < TCOUNT_W'(TYPE_SLOTS)) ? cfg.type_count
                                                        : TCOUNT_W'(TYPE_SLOTS);
    tbl_word = data_byte[3] ? cfg.lengths_hi : cfg.lengths_lo;
    tbl_raw  = tbl_word[{data_byte[2:0], 3'b000} +: BYTE_W];
    tlen     = (tbl_raw < MIN_TABLE_LEN) ? MIN_TABLE_LEN : tbl_raw;
    rcount_inc = rcount + 1'b1;
    if (cur_type == BUS_TYPE) begin
      bad_count = data_byte > BUS_COUNT_MAX;
      plen      = {1'b0, data_byte} + (BYTE_W+1)'(cfg.bus_ovh);
    end else begin
      bad_count = data_byte > BYTE_W'(cfg.chunk_max);
      plen      = {1'b0, data_byte} + (BYTE_W+1)'(cfg.chunk_ovh);
    end
  end

  // Advance the receive state on each accepted item
  always_comb begin
    state_next    = state;
    cur_type_next = cur_type;
    rcount_next   = rcount;
    exp_len_next  = exp_len;
    wr.we         = 1'b0;
    wr.addr       = rcount[ADDR_W-1:0];
    wr.data       = data_byte;
    req.start     = 1'b0;
    req.ftype     = cur_type;
    req.flen      = LEN_W'(exp_len);
    if (fire) begin
      case (state)
        S_HUNT: begin
          if (data_byte == cfg.start_byte) begin
            wr.we      = 1'b1;
            wr.addr    = '0;
            state_next = S_TYPE;
          end
        end
        S_TYPE: begin
          if (data_byte >= BYTE_W'(limit)) begin
            // unknown type: drop and restart the hunt
            state_next = S_HUNT;
          end else begin
            cur_type_next = data_byte[TYPE_W-1:0];
            wr.we         = 1'b1;
            wr.addr       = ADDR_W'(1);
            rcount_next   = CNT_W'(2);
            if (tlen == MIN_TABLE_LEN) begin
              // two-byte frame completes on its type byte
              req.start    = 1'b1;
              req.ftype    = data_byte[TYPE_W-1:0];
              req.flen     = LEN_W'(2);
              exp_len_next = CNT_W'(2);
              state_next   = S_HUNT;
            end else if (is_variable(data_byte[TYPE_W-1:0])) begin
              exp_len_next = COUNT_POS;
              state_next   = S_BODY;
            end else if (tlen > BYTE_W'(MAX_FRAME_LEN)) begin
              state_next = S_HUNT;
            end else begin
              exp_len_next = tlen[CNT_W-1:0];
              state_next   = S_BODY;
            end
          end
        end
        S_BODY: begin
          if (rcount >= CNT_W'(MAX_FRAME_LEN) || rcount >= exp_len) begin
            state_next = S_HUNT;
          end else begin
            wr.we       = 1'b1;
            rcount_next = rcount_inc;
            if (is_variable(cur_type) && rcount_inc == COUNT_POS) begin
              // count byte: patch the length or abandon the frame
              if (bad_count || plen > (BYTE_W+1)'(MAX_FRAME_LEN) ||
                  plen < (BYTE_W+1)'(COUNT_POS)) begin
                state_next = S_HUNT;
              end else begin
                exp_len_next = plen[CNT_W-1:0];
                if (plen == (BYTE_W+1)'(COUNT_POS)) begin
                  req.start  = 1'b1;
                  req.flen   = LEN_W'(COUNT_POS);
                  state_next = S_HUNT;
                end
              end
            end else if (rcount_inc >= exp_len) begin
              req.start  = 1'b1;
              state_next = S_HUNT;
            end
          end
        end
        default: begin
          state_next = S_HUNT;
        end
      endcase
    end
  end

  // Hold receive state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_HUNT;
      cur_type <= '0;
      rcount   <= '0;
      exp_len  <= '0;
    end else begin
      state    <= state_next;
      cur_type <= cur_type_next;
      rcount   <= rcount_next;
      exp_len  <= exp_len_next;
    end
  end

endmodule

`default_nettype wire

### hdl/tfd_emit.sv
// ----------------------------------------------------------------------------
// Frame emitter
// Reads a completed frame out of the frame store one byte per cycle while
// frame_out is not held off, through a read stage and an output register,
// tagging each byte with its index, type, length and last marker.
// ----------------------------------------------------------------------------
`default_nettype none

module tfd_emit import tfd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  emit_req_t         req,
  output logic              busy,
  output mem_rd_t           rd,
  input  logic [BYTE_W-1:0] rdata,
  tfd_frame_if.source       frame_out
);

  logic               issuing;
  logic [CNT_W-1:0]   rd_cnt;
  logic [TYPE_W-1:0]  e_type;
  logic [LEN_W-1:0]   e_len;

  logic               s1_valid;
  logic [INDEX_W-1:0] s1_index;
  logic               s1_last;
  logic [TYPE_W-1:0]  s1_type;
  logic [LEN_W-1:0]   s1_len;

  logic               o_valid;
  logic [BYTE_W-1:0]  o_byte;
  logic [INDEX_W-1:0] o_index;
  logic [TYPE_W-1:0]  o_type;
  logic [LEN_W-1:0]   o_len;
  logic               o_last;

  logic               load_out;
  logic               issue;
  logic [CNT_W-1:0]   cnt_inc;
  logic               final_rd;

  // Move read data forward when the output register frees up
  assign load_out = s1_valid && (!o_valid || frame_out.ready);
  assign issue    = issuing && (!s1_valid || load_out);
  assign cnt_inc  = rd_cnt + 1'b1;
  assign final_rd = (cnt_inc == CNT_W'(e_len));

  assign busy    = issuing;
  assign rd.re   = issue;
  assign rd.addr = rd_cnt[ADDR_W-1:0];

  assign frame_out.valid        = o_valid;
  assign frame_out.frame_byte   = o_byte;
  assign frame_out.byte_index   = o_index;
  assign frame_out.frame_type   = o_type;
  assign frame_out.frame_length = o_len;
  assign frame_out.last_byte    = o_last;

  // Read sequencer and stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing  <= 1'b0;
      rd_cnt   <= '0;
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (req.start) begin
        issuing <= 1'b1;
        rd_cnt  <= '0;
      end else if (issue) begin
        rd_cnt <= cnt_inc;
        if (final_rd) begin
          issuing <= 1'b0;
        end
      end
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (load_out) begin
        s1_valid <= 1'b0;
      end
      if (load_out) begin
        o_valid <= 1'b1;
      end else if (frame_out.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // Frame tags and payload
  always_ff @(posedge clk) begin
    if (req.start) begin
      e_type <= req.ftype;
      e_len  <= req.flen;
    end
    if (issue) begin
      s1_index <= rd_cnt[INDEX_W-1:0];
      s1_last  <= final_rd;
      s1_type  <= e_type;
      s1_len   <= e_len;
    end
    if (load_out) begin
      o_byte  <= rdata;
      o_index <= s1_index;
      o_type  <= s1_type;
      o_len   <= s1_len;
      o_last  <= s1_last;
    end
  end

endmodule

`default_nettype wire

### hdl/typed_frame_deframer.sv
// ----------------------------------------------------------------------------
// Typed frame deframer
// Start byte / type / length deframer with a single-port-read frame store.
// ----------------------------------------------------------------------------
// Bytes enter on byte_in at one per cycle while a frame is being received;
// each byte is written into a 64-entry frame store. When a frame completes,
// byte_in stalls while the emitter reads the store back one byte per cycle
// through its single read port, and stays stalled longer while frame_out is
// held off; the bytes leave on frame_out, one per cycle when the sink is
// ready, with a two-item pipeline (read stage plus output register) so
// reception resumes while the last bytes are still waiting.
// Configuration writes on cfg_wr are always taken and must only be issued
// while the block is idle.
`default_nettype none

module typed_frame_deframer import tfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  tfd_byte_if.sink    byte_in,
  tfd_frame_if.source frame_out,
  tfd_cfg_if.sink     cfg_wr
);

  cfg_t              cfg;
  mem_wr_t           wr;
  mem_rd_t           rd;
  emit_req_t         req;
  logic              busy;
  logic              fire;
  logic [BYTE_W-1:0] rdata;

  assign cfg_wr.ready = 1'b1;
  assign byte_in.ready = !busy;
  assign fire = byte_in.valid && byte_in.ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte <= '0;
      cfg.type_count <= TCOUNT_W'(13);
      cfg.lengths_lo <= '0;
      cfg.lengths_hi <= '0;
      cfg.bus_ovh    <= OVH_W'(4);
      cfg.chunk_ovh  <= OVH_W'(4);
      cfg.chunk_max  <= OVH_W'(32);
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      case (cfg_reg_e'(cfg_wr.index))
        REG_START_BYTE: cfg.start_byte <= cfg_wr.data[BYTE_W-1:0];
        REG_TYPE_COUNT: cfg.type_count <= cfg_wr.data[TCOUNT_W-1:0];
        REG_LENGTHS_LO: cfg.lengths_lo <= cfg_wr.data;
        REG_LENGTHS_HI: cfg.lengths_hi <= cfg_wr.data;
        REG_BUS_OVH:    cfg.bus_ovh    <= cfg_wr.data[OVH_W-1:0];
        REG_CHUNK_OVH:  cfg.chunk_ovh  <= cfg_wr.data[OVH_W-1:0];
        REG_CHUNK_MAX:  cfg.chunk_max  <= cfg_wr.data[OVH_W-1:0];
        default: ;
      endcase
    end
  end

  tfd_hunt u_hunt (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .data_byte (byte_in.data_byte),
    .cfg       (cfg),
    .wr        (wr),
    .req       (req)
  );

  tfd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_FRAME_LEN)
  ) u_store (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd.re),
    .raddr (rd.addr),
    .rdata (rdata)
  );

  tfd_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .busy      (busy),
    .rd        (rd),
    .rdata     (rdata),
    .frame_out (frame_out)
  );

endmodule

`default_nettype wire

### hdl/tfd_checker.sv
// ----------------------------------------------------------------------------
// Typed frame deframer port checker
// Watches the frame output channel for ordering and tagging slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "typed_frame_deframer_defines.svh"

module tfd_checker import tfd_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [BYTE_W-1:0]  frame_byte,
  input logic [INDEX_W-1:0] byte_index,
  input logic [TYPE_W-1:0]  frame_type,
  input logic [LEN_W-1:0]   frame_length,
  input logic               last_byte
);

  // Stalled item holds
  `TFD_ASSERT(a_stall_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(byte_index) && $stable(frame_type) && $stable(frame_length) && $stable(last_byte), "stalled frame item changed")

  // Last marker sits on the final index
  `TFD_ASSERT(a_last_tag, clk, rst, out_valid |-> (last_byte == ((LEN_W'(byte_index) + 7'd1) == frame_length)), "last marker disagrees with index and length")

  // Bytes of one frame follow back to back in order
  `TFD_ASSERT(a_next_byte, clk, rst, out_valid && out_ready && !last_byte |=> out_valid && (LEN_W'(byte_index) == LEN_W'($past(byte_index)) + 7'd1) && $stable(frame_length) && $stable(frame_type), "frame byte missing or out of order")

  // Reset empties the output
  `TFD_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "output valid after reset")

endmodule

bind typed_frame_deframer tfd_checker u_tfd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (frame_out.valid),
  .out_ready    (frame_out.ready),
  .frame_byte   (frame_out.frame_byte),
  .byte_index   (frame_out.byte_index),
  .frame_type   (frame_out.frame_type),
  .frame_length (frame_out.frame_length),
  .last_byte    (frame_out.last_byte)
);

`default_nettype wire

### bench/typed_frame_deframer_checker.sv
// ----------------------------------------------------------------------------
// Typed frame deframer checker
// Watches the byte, frame and configuration channels, rebuilds the expected
// frame items from every accepted byte and compares each emitted item with
// the oldest expected one, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module typed_frame_deframer_checker import tfd_pkg::*; (
  input  logic clk,
  input  logic rst,
  tfd_byte_if  byte_ch,
  tfd_frame_if frame_ch,
  tfd_cfg_if   cfg_ch,
  output int   mismatches,
  output int   beats_due,
  output logic hunting
);

  typedef struct packed {
    logic [BYTE_W-1:0]  frame_byte;
    logic [INDEX_W-1:0] byte_index;
    logic [TYPE_W-1:0]  frame_type;
    logic [LEN_W-1:0]   frame_length;
    logic               last_byte;
  } frame_beat_t;

  // Register mirror and hunt state
  cfg_t              regs;
  logic              in_frame;
  logic [TYPE_W-1:0] cur_type;
  int                rcvd;
  int                exp_len;
  logic [BYTE_W-1:0] store [MAX_FRAME_LEN];
  frame_beat_t       expected_beats [$];

  function automatic int table_len(input logic [TYPE_W-1:0] t);
    logic [CFG_DATA_W-1:0] word;
    int len;
    word = t[3] ? regs.lengths_hi : regs.lengths_lo;
    len = int'(word[int'(t[2:0]) * 8 +: 8]);
    return (len < 2) ? 2 : len;
  endfunction

  function automatic bit variable_type(input logic [TYPE_W-1:0] t);
    return t == BUS_TYPE || t == CHUNK_TYPE_A || t == CHUNK_TYPE_B;
  endfunction

  task automatic restart_hunt();
    in_frame = 1'b0;
    rcvd = 0;
    exp_len = 0;
  endtask

  // Queue every byte of the finished frame, then go back to hunting
  task automatic release_frame(input int len);
    frame_beat_t beat;
    for (int i = 0; i < len; i++) begin
      beat.frame_byte   = store[i];
      beat.byte_index   = INDEX_W'(i);
      beat.frame_type   = cur_type;
      beat.frame_length = LEN_W'(len);
      beat.last_byte    = (i == len - 1);
      expected_beats.push_back(beat);
    end
    in_frame = 1'b0;
    rcvd = 0;
  endtask

  // Advance the deframer by one received byte
  task automatic deframe_byte(input logic [BYTE_W-1:0] rx);
    int lim;
    int tl;
    int len;
    bit bad;
    if (!in_frame) begin
      if (rcvd == 0) begin
        if (rx == regs.start_byte) begin
          store[0] = rx;
          rcvd = 1;
        end
      end else begin
        lim = (regs.type_count < TYPE_SLOTS) ? int'(regs.type_count) : TYPE_SLOTS;
        if (int'(rx) >= lim) begin
          restart_hunt();
        end else begin
          cur_type = rx[TYPE_W-1:0];
          tl = table_len(cur_type);
          store[1] = rx;
          rcvd = 2;
          if (tl == 2) begin
            exp_len = 2;
            release_frame(2);
          end else if (variable_type(cur_type)) begin
            exp_len = COUNT_POS;
            in_frame = 1'b1;
          end else if (tl > MAX_FRAME_LEN) begin
            restart_hunt();
          end else begin
            exp_len = tl;
            in_frame = 1'b1;
          end
        end
      end
    end else if (rcvd >= MAX_FRAME_LEN || rcvd >= exp_len) begin
      restart_hunt();
    end else begin
      store[rcvd] = rx;
      rcvd++;
      if (variable_type(cur_type) && rcvd == COUNT_POS) begin
        // count byte sets the frame length
        if (cur_type == BUS_TYPE) begin
          bad = rx > BUS_COUNT_MAX;
          len = int'(rx) + int'(regs.bus_ovh);
        end else begin
          bad = rx > regs.chunk_max;
          len = int'(rx) + int'(regs.chunk_ovh);
        end
        if (bad || len > MAX_FRAME_LEN || len < COUNT_POS) begin
          restart_hunt();
        end else begin
          exp_len = len;
          if (len == COUNT_POS) release_frame(len);
        end
      end else if (rcvd >= exp_len) begin
        release_frame(exp_len);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                             input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : track
    frame_beat_t want;
    if (rst) begin
      regs.start_byte = '0;
      regs.type_count = TCOUNT_W'(13);
      regs.lengths_lo = '0;
      regs.lengths_hi = '0;
      regs.bus_ovh    = OVH_W'(4);
      regs.chunk_ovh  = OVH_W'(4);
      regs.chunk_max  = OVH_W'(32);
      cur_type = '0;
      restart_hunt();
      expected_beats.delete();
      mismatches = 0;
    end else begin
      // compare an emitted item with the oldest expected one
      if (frame_ch.valid && frame_ch.ready) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected frame item: frame_byte %0h byte_index %0d",
                 frame_ch.frame_byte, frame_ch.byte_index);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          check_field("frame_byte", want.frame_byte, frame_ch.frame_byte);
          check_field("byte_index", BYTE_W'(want.byte_index), BYTE_W'(frame_ch.byte_index));
          check_field("frame_type", BYTE_W'(want.frame_type), BYTE_W'(frame_ch.frame_type));
          check_field("frame_length", BYTE_W'(want.frame_length),
                      BYTE_W'(frame_ch.frame_length));
          check_field("last_byte", BYTE_W'(want.last_byte), BYTE_W'(frame_ch.last_byte));
        end
      end
      // mirror register writes
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_START_BYTE: regs.start_byte = cfg_ch.data[BYTE_W-1:0];
          REG_TYPE_COUNT: regs.type_count = cfg_ch.data[TCOUNT_W-1:0];
          REG_LENGTHS_LO: regs.lengths_lo = cfg_ch.data;
          REG_LENGTHS_HI: regs.lengths_hi = cfg_ch.data;
          REG_BUS_OVH:    regs.bus_ovh    = cfg_ch.data[OVH_W-1:0];
          REG_CHUNK_OVH:  regs.chunk_ovh  = cfg_ch.data[OVH_W-1:0];
          REG_CHUNK_MAX:  regs.chunk_max  = cfg_ch.data[OVH_W-1:0];
          default: ;
        endcase
      end
      if (byte_ch.valid && byte_ch.ready) deframe_byte(byte_ch.data_byte);
    end
    beats_due = expected_beats.size();
    hunting = !in_frame && rcvd == 0;
  end

endmodule

### bench/typed_frame_deframer_test.sv
// ----------------------------------------------------------------------------
// Typed frame deframer testbench
// Drives byte streams of well-formed, broken and noisy frames through the
// deframer under several register settings, with random gaps on the byte
// and frame channels and one long frame-side hold-off. The checker beside
// the block predicts and compares every frame item.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module typed_frame_deframer_test;
  import tfd_pkg::*;

  localparam int RX_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int CYCLE_LIMIT    = 200000;
  localparam logic [BYTE_W-1:0] FILL_BYTE = 8'hFF;

  logic clk;
  logic rst;
  int   mismatches;
  int   beats_due;
  logic hunting;
  int   cycle_count;
  int   bytes_sent;
  bit   src_gaps_on;
  bit   sink_gaps_on;
  bit   rx_hold_req;
  bit   var_frames_on;
  cfg_t stim_cfg;

  tfd_byte_if  byte_ch ();
  tfd_frame_if frame_ch ();
  tfd_cfg_if   cfg_ch ();

  typed_frame_deframer dut (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_ch),
    .frame_out (frame_ch),
    .cfg_wr    (cfg_ch)
  );

  typed_frame_deframer_checker frame_monitor (
    .clk        (clk),
    .rst        (rst),
    .byte_ch    (byte_ch),
    .frame_ch   (frame_ch),
    .cfg_ch     (cfg_ch),
    .mismatches (mismatches),
    .beats_due  (beats_due),
    .hunting    (hunting)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // End a hung run
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic int type_limit();
    return (stim_cfg.type_count < TYPE_SLOTS) ? int'(stim_cfg.type_count) : TYPE_SLOTS;
  endfunction

  function automatic int table_entry(input int t);
    logic [CFG_DATA_W-1:0] word;
    int len;
    word = (t < 8) ? stim_cfg.lengths_lo : stim_cfg.lengths_hi;
    len = int'(word[(t % 8) * 8 +: 8]);
    return (len < 2) ? 2 : len;
  endfunction

  function automatic bit is_var(input int t);
    return t == int'(BUS_TYPE) || t == int'(CHUNK_TYPE_A) || t == int'(CHUNK_TYPE_B);
  endfunction

  // Random table: mostly short frames, now and then long or oversize
  function automatic logic [CFG_DATA_W-1:0] random_lengths();
    logic [CFG_DATA_W-1:0] word;
    int r;
    for (int k = 0; k < 8; k++) begin
      r = $urandom_range(99);
      if (r < 10) word[k*8 +: 8] = 8'($urandom_range(1));
      else if (r < 85) word[k*8 +: 8] = 8'($urandom_range(10, 2));
      else if (r < 90) word[k*8 +: 8] = 8'(MAX_FRAME_LEN);
      else if (r < 95) word[k*8 +: 8] = 8'($urandom_range(255, MAX_FRAME_LEN + 1));
      else word[k*8 +: 8] = 8'($urandom_range(30, 11));
    end
    return word;
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.start_byte = 8'($urandom_range(255));
    c.type_count = TCOUNT_W'($urandom_range(16, 1));
    c.lengths_lo = random_lengths();
    c.lengths_hi = random_lengths();
    c.bus_ovh    = OVH_W'($urandom_range(56, 4));
    c.chunk_ovh  = OVH_W'($urandom_range(60, 4));
    c.chunk_max  = OVH_W'($urandom_range(60, 0));
    return c;
  endfunction

  // Offer one byte and hold it until accepted, then maybe idle
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    byte_ch.valid <= 1'b1;
    byte_ch.data_byte <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
    gap = src_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Push filler until the deframer hunts again, then wait for all frame items
  task automatic quiesce();
    byte_ch.valid <= 1'b0;
    @(negedge clk);
    while (!hunting) begin
      @(posedge clk);
      send_byte(FILL_BYTE);
      byte_ch.valid <= 1'b0;
      @(negedge clk);
    end
    while (beats_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic apply_config(input cfg_t c);
    stim_cfg = c;
    write_reg(REG_START_BYTE, CFG_DATA_W'(c.start_byte));
    write_reg(REG_TYPE_COUNT, CFG_DATA_W'(c.type_count));
    write_reg(REG_LENGTHS_LO, c.lengths_lo);
    write_reg(REG_LENGTHS_HI, c.lengths_hi);
    write_reg(REG_BUS_OVH, CFG_DATA_W'(c.bus_ovh));
    write_reg(REG_CHUNK_OVH, CFG_DATA_W'(c.chunk_ovh));
    write_reg(REG_CHUNK_MAX, CFG_DATA_W'(c.chunk_max));
    cfg_ch.valid <= 1'b0;
  endtask

  // Well-formed frame of type t; cnt is used only by the variable types
  task automatic send_frame(input int t, input int cnt);
    int tl;
    int n;
    tl = table_entry(t);
    send_byte(stim_cfg.start_byte);
    send_byte(8'(t));
    if (tl == 2) return;
    if (is_var(t)) begin
      send_byte(8'(cnt));
      n = cnt + ((t == int'(BUS_TYPE)) ? int'(stim_cfg.bus_ovh) : int'(stim_cfg.chunk_ovh)) - 3;
    end else begin
      if (tl > MAX_FRAME_LEN) return;
      n = tl - 2;
    end
    repeat (n) send_byte(8'($urandom_range(255)));
  endtask

  task automatic random_frame();
    int lim;
    int t;
    int hi;
    int cnt;
    lim = type_limit();
    t = $urandom_range(lim - 1, 0);
    if (var_frames_on && $urandom_range(9) < 3) begin
      case ($urandom_range(2))
        0:       t = int'(BUS_TYPE);
        1:       t = int'(CHUNK_TYPE_A);
        default: t = int'(CHUNK_TYPE_B);
      endcase
      if (t >= lim) t = $urandom_range(lim - 1, 0);
    end
    if (!var_frames_on && is_var(t)) t = 0;
    if (t == int'(BUS_TYPE)) begin
      cnt = $urandom_range(int'(BUS_COUNT_MAX), 0);
    end else begin
      hi = stim_cfg.chunk_max;
      if (hi > MAX_FRAME_LEN - int'(stim_cfg.chunk_ovh)) hi = MAX_FRAME_LEN - stim_cfg.chunk_ovh;
      if (hi > 6) hi = 6;
      cnt = $urandom_range(hi, 0);
    end
    send_frame(t, cnt);
  endtask

  // Start byte then a type at or above the type count
  task automatic send_bad_type();
    logic [BYTE_W-1:0] b;
    b = 8'($urandom_range(255, type_limit()));
    if ($urandom_range(3) == 0 && int'(stim_cfg.start_byte) >= type_limit())
      b = stim_cfg.start_byte;
    send_byte(stim_cfg.start_byte);
    send_byte(b);
  endtask

  // Noise and broken frames
  task automatic send_glitch();
    int k;
    int v;
    int cnt;
    logic [BYTE_W-1:0] b;
    k = $urandom_range(9);
    if (k < 3) begin
      // line noise between frames
      repeat ($urandom_range(3, 1)) begin
        b = 8'($urandom_range(255));
        if (b == stim_cfg.start_byte) b = ~b;
        send_byte(b);
      end
    end else if (k < 6) begin
      send_bad_type();
    end else if (k < 9) begin
      // variable type with a count that cannot fit
      case ($urandom_range(2))
        0:       v = int'(BUS_TYPE);
        1:       v = int'(CHUNK_TYPE_A);
        default: v = int'(CHUNK_TYPE_B);
      endcase
      if (v >= type_limit() || table_entry(v) == 2) begin
        send_bad_type();
      end else begin
        if (v == int'(BUS_TYPE))
          cnt = $urandom_range(255, int'(BUS_COUNT_MAX) + 1);
        else if ($urandom_range(1) == 1 &&
                 int'(stim_cfg.chunk_max) + int'(stim_cfg.chunk_ovh) > MAX_FRAME_LEN)
          cnt = $urandom_range(stim_cfg.chunk_max, MAX_FRAME_LEN + 1 - stim_cfg.chunk_ovh);
        else
          cnt = $urandom_range(255, int'(stim_cfg.chunk_max) + 1);
        send_byte(stim_cfg.start_byte);
        send_byte(8'(v));
        send_byte(8'(cnt));
      end
    end else begin
      // cut-off frame: whatever follows is swallowed until it resyncs
      send_byte(stim_cfg.start_byte);
      send_byte(8'($urandom_range(type_limit() - 1, 0)));
      repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic run_random(input int n_bytes);
    int target;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      if ($urandom_range(3) == 0) send_glitch();
      else random_frame();
    end
  endtask

  // Frame sink: random ready gaps, or one long hold-off on request
  initial begin : frame_sink
    int run;
    int gap;
    frame_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        frame_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        frame_ch.ready <= 1'b1;
        run = sink_gaps_on ? $urandom_range(12, 1) : 1;
        repeat (run) @(posedge clk);
        gap = sink_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
          frame_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    cfg_t plan;
    rst = 1'b1;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_START_BYTE;
    cfg_ch.data = '0;
    src_gaps_on = 1'b1;
    sink_gaps_on = 1'b1;
    rx_hold_req = 1'b0;
    var_frames_on = 1'b1;
    stim_cfg.start_byte = '0;
    stim_cfg.type_count = TCOUNT_W'(13);
    stim_cfg.lengths_lo = '0;
    stim_cfg.lengths_hi = '0;
    stim_cfg.bus_ovh = OVH_W'(4);
    stim_cfg.chunk_ovh = OVH_W'(4);
    stim_cfg.chunk_max = OVH_W'(32);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Registers at reset: every type is two bytes long
    send_byte(8'h00); send_byte(8'h0C);
    send_byte(8'h00); send_byte(8'h0D);
    quiesce();

    // Directed cases on a hand-made table
    plan.start_byte = 8'hA5;
    plan.type_count = TCOUNT_W'(13);
    plan.lengths_lo = 64'h02_03_41_40_05_03_01_00;
    plan.lengths_hi = 64'h03_03_03_06_07_FF_02_04;
    plan.bus_ovh    = OVH_W'(4);
    plan.chunk_ovh  = OVH_W'(4);
    plan.chunk_max  = OVH_W'(5);
    apply_config(plan);
    send_byte(8'h00);
    // zero table length gives a two-byte frame
    send_byte(8'hA5); send_byte(8'h00);
    // start byte in the type slot is dropped, not taken as a new start
    send_byte(8'hA5); send_byte(8'hA5); send_byte(8'h07);
    // fixed length above the frame limit
    send_byte(8'hA5); send_byte(8'h05);
    // bus count too large, then the smallest bus frame
    send_byte(8'hA5); send_byte(8'h02); send_byte(8'h09);
    send_byte(8'hA5); send_byte(8'h02); send_byte(8'h00); send_byte(8'hFF);
    // chunk count above its maximum
    send_byte(8'hA5); send_byte(8'h06); send_byte(8'h06);
    // variable type whose table length ends it at the type byte
    send_byte(8'hA5); send_byte(8'h09);
    // plain fixed frame
    send_byte(8'hA5); send_byte(8'h03); send_byte(8'h80); send_byte(8'h7F);
    send_byte(8'h01);
    quiesce();

    // Largest overheads: a full-size frame sent at full rate while the sink
    // holds off, so the frame completes and the input stalls inside the hold
    plan = random_config();
    plan.start_byte = 8'h00;
    plan.type_count = TCOUNT_W'(16);
    plan.lengths_lo[23:16] = 8'd3;
    plan.lengths_lo[55:48] = 8'd3;
    plan.lengths_hi[15:8]  = 8'd3;
    plan.bus_ovh   = OVH_W'(56);
    plan.chunk_ovh = OVH_W'(60);
    plan.chunk_max = OVH_W'(60);
    apply_config(plan);
    rx_hold_req = 1'b1;
    src_gaps_on = 1'b0;
    send_frame(int'(BUS_TYPE), int'(BUS_COUNT_MAX));
    src_gaps_on = 1'b1;
    var_frames_on = 1'b0;
    run_random(8);
    var_frames_on = 1'b1;
    quiesce();

    // Single valid type, no chunks allowed, no idling on either side
    plan = random_config();
    plan.start_byte = 8'hFF;
    plan.type_count = TCOUNT_W'(1);
    plan.bus_ovh    = OVH_W'(4);
    plan.chunk_ovh  = OVH_W'(4);
    plan.chunk_max  = OVH_W'(0);
    apply_config(plan);
    src_gaps_on = 1'b0;
    sink_gaps_on = 1'b0;
    run_random(8);
    src_gaps_on = 1'b1;
    sink_gaps_on = 1'b1;
    quiesce();

    // Random settings; the sender pauses midway until all frames are out
    apply_config(random_config());
    run_random(6);
    quiesce();
    run_random(6);
    quiesce();

    apply_config(random_config());
    run_random(8);
    quiesce();

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
